### hdl/crsi_pkg.sv
// shared types and constants for the code range set insert core
`timescale 1ns / 1ps

package crsi_pkg;

    localparam int MAX_RANGES_DEF = 64;

    localparam int CODE_W   = 16;
    localparam int LEN_W    = 17;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_CODE = 1'b1;

    localparam logic [CODE_W-1:0] MIN_CODE_RST  = 16'h0020;
    localparam logic [CODE_W-1:0] SKIP_CODE_RST = 16'hFEFF;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXTENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ     = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] first;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_MERGE,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_PLACE,
        S_FINISH
    } state_t;

endpackage

### hdl/code_range_set_insert_core.sv
// code range set: sorted range table with insert, merge and indexed read
`timescale 1ns / 1ps

// Keeps up to MAX_RANGES disjoint, non-adjacent code ranges in a single-port-read,
// single-port-write table and handles one item at a time; s_tready is low while
// an item is in work. An insert walks the table one entry per cycle through the
// registered read port, and a new range in the middle or a merge after an
// extension moves the tail of the table one entry per cycle through the same
// port. A finished result sits in the output register, and the next item is
// taken meanwhile; an item only waits in S_FINISH while the result before it
// has not been taken on m_tready.
// Configuration writes are always taken and should only be issued while idle.
module code_range_set_insert_core
    import crsi_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // code[15:0], entry_index[21:16], zero fill
    input  logic [0:0]            s_tuser,   // operation[0]
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // status[2:0], range_total[9:3],
                                             // entry_first[25:10], entry_length[42:26]
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CODE_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int CMP_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

    // range table
    entry_t mem [MAX_RANGES];
    entry_t rd_entry_reg;
    logic [IDX_W-1:0] raddr;
    logic             mem_we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;

    state_t state_reg, state_next;

    logic [CODE_W-1:0]  min_code_reg, skip_code_reg;
    logic               op_reg, op_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   ins_reg, ins_next;
    logic [CODE_W-1:0]  cur_first_reg, cur_first_next;
    logic [LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CODE_W-1:0]  first_reg, first_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               in_fire;
    logic               in_op;
    logic [CODE_W-1:0]  in_code;
    logic [INDEX_W-1:0] in_idx;
    logic               in_ignore;
    logic               out_free;

    logic [CODE_W+1:0]  rd_end;
    logic [CODE_W+1:0]  code_ext;
    logic               scan_present, scan_extend, scan_below, scan_touch;
    logic               merge_touch;
    logic               table_full;
    logic [CNT_W:0]     ptr_inc, ptr_inc2, used_ext;
    logic               idx_ok;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_fire   = s_tvalid && s_tready;
    assign in_op     = s_tuser[0];
    assign in_code   = s_tdata[CODE_W-1:0];
    assign in_idx    = s_tdata[CODE_W+INDEX_W-1:CODE_W];
    assign in_ignore = (in_code < min_code_reg) || (in_code == skip_code_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    // compares against the entry that the read port returns this cycle
    assign rd_end       = {2'b00, rd_entry_reg.first} + {1'b0, rd_entry_reg.len};
    assign code_ext     = {2'b00, code_reg};
    assign scan_present = (code_reg >= rd_entry_reg.first) && (code_ext < rd_end);
    assign scan_extend  = (code_ext == rd_end);
    assign scan_below   = (code_reg < rd_entry_reg.first);
    assign scan_touch   = ({1'b0, code_reg} + 17'd1) == {1'b0, rd_entry_reg.first};
    assign merge_touch  = ({2'b00, cur_first_reg} + {1'b0, cur_len_reg})
                          == {2'b00, rd_entry_reg.first};
    assign table_full   = (used_reg == CNT_W'(MAX_RANGES));
    assign ptr_inc      = (CNT_W+1)'(ptr_reg) + (CNT_W+1)'(1);
    assign ptr_inc2     = (CNT_W+1)'(ptr_reg) + (CNT_W+1)'(2);
    assign used_ext     = (CNT_W+1)'(used_reg);
    assign idx_ok       = (CMP_W'(idx_reg) < CMP_W'(used_reg))
                          && (CMP_W'(idx_reg) < CMP_W'(MAX_RANGES));

    // table memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rd_entry_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_code_reg  <= MIN_CODE_RST;
            skip_code_reg <= SKIP_CODE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_CODE:  min_code_reg  <= cfg_data;
                REG_SKIP_CODE: skip_code_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        code_reg      <= code_next;
        idx_reg       <= idx_next;
        ptr_reg       <= ptr_next;
        ins_reg       <= ins_next;
        cur_first_reg <= cur_first_next;
        cur_len_reg   <= cur_len_next;
        status_reg    <= status_next;
        first_reg     <= first_next;
        len_reg       <= len_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_READ) begin
                        state_next = S_READ;
                    end else if (in_ignore) begin
                        state_next = S_FINISH;
                    end else if (used_reg == '0) begin
                        state_next = S_PLACE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_READ: state_next = S_FINISH;
            S_SCAN: begin
                if (scan_present) begin
                    state_next = S_FINISH;
                end else if (scan_extend) begin
                    state_next = (ptr_inc < used_ext) ? S_MERGE : S_FINISH;
                end else if (scan_below) begin
                    if (table_full || scan_touch) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SHIFT_UP;
                    end
                end else if (ptr_inc >= used_ext) begin
                    state_next = table_full ? S_FINISH : S_PLACE;
                end
            end
            S_MERGE: begin
                if (merge_touch && (ptr_inc2 < used_ext)) begin
                    state_next = S_SHIFT_DN;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_DN: begin
                if (ptr_inc2 >= used_ext) begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_UP: begin
                if ((ptr_reg - CNT_W'(1)) == ins_reg) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: state_next = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and table access
    always_comb begin
        op_next        = op_reg;
        code_next      = code_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        ptr_next       = ptr_reg;
        ins_next       = ins_reg;
        cur_first_next = cur_first_reg;
        cur_len_next   = cur_len_reg;
        status_next    = status_reg;
        first_next     = first_reg;
        len_next       = len_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        raddr          = ptr_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        waddr          = ptr_reg[IDX_W-1:0];
        wdata          = rd_entry_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    op_next    = in_op;
                    code_next  = in_code;
                    idx_next   = in_idx;
                    first_next = '0;
                    len_next   = '0;
                    ptr_next   = '0;
                    ins_next   = '0;
                    raddr      = '0;
                    if (in_op == OP_READ) begin
                        status_next = ST_READ;
                        raddr       = IDX_W'(in_idx);
                    end else if (in_ignore) begin
                        status_next = ST_IGNORED;
                    end else begin
                        status_next = ST_NEW;
                    end
                end
            end
            S_READ: begin
                if (idx_ok) begin
                    first_next = rd_entry_reg.first;
                    len_next   = rd_entry_reg.len;
                end
            end
            S_SCAN: begin
                raddr = ptr_inc[IDX_W-1:0];
                if (scan_present) begin
                    status_next = ST_PRESENT;
                end else if (scan_extend) begin
                    status_next    = ST_EXTENDED;
                    cur_first_next = rd_entry_reg.first;
                    cur_len_next   = rd_entry_reg.len + LEN_W'(1);
                    if (ptr_inc >= used_ext) begin
                        mem_we     = 1'b1;
                        wdata.first = rd_entry_reg.first;
                        wdata.len   = rd_entry_reg.len + LEN_W'(1);
                    end
                end else if (scan_below) begin
                    if (table_full) begin
                        status_next = ST_FULL;
                    end else if (scan_touch) begin
                        // new code sits right under this range: grow it downward
                        mem_we      = 1'b1;
                        wdata.first = code_reg;
                        wdata.len   = rd_entry_reg.len + LEN_W'(1);
                    end else begin
                        ins_next = ptr_reg;
                        ptr_next = used_reg;
                        raddr    = IDX_W'(used_reg - CNT_W'(1));
                    end
                end else begin
                    ptr_next = ptr_inc[CNT_W-1:0];
                    if (ptr_inc >= used_ext) begin
                        if (table_full) begin
                            status_next = ST_FULL;
                        end else begin
                            ins_next = used_reg;
                        end
                    end
                end
            end
            S_MERGE: begin
                raddr  = ptr_inc2[IDX_W-1:0];
                mem_we = 1'b1;
                wdata.first = cur_first_reg;
                if (merge_touch) begin
                    wdata.len = cur_len_reg + rd_entry_reg.len;
                    if (ptr_inc2 >= used_ext) begin
                        used_next = used_reg - CNT_W'(1);
                    end else begin
                        ptr_next = ptr_inc[CNT_W-1:0];
                    end
                end else begin
                    wdata.len = cur_len_reg;
                end
            end
            S_SHIFT_DN: begin
                // pull the tail down over the merged entry
                raddr    = ptr_inc2[IDX_W-1:0];
                mem_we   = 1'b1;
                ptr_next = ptr_inc[CNT_W-1:0];
                if (ptr_inc2 >= used_ext) begin
                    used_next = used_reg - CNT_W'(1);
                end
            end
            S_SHIFT_UP: begin
                // open a slot: move entries up, highest first
                raddr    = IDX_W'(ptr_reg - CNT_W'(2));
                mem_we   = 1'b1;
                ptr_next = ptr_reg - CNT_W'(1);
            end
            S_PLACE: begin
                mem_we      = 1'b1;
                waddr       = ins_reg[IDX_W-1:0];
                wdata.first = code_reg;
                wdata.len   = LEN_W'(1);
                used_next   = used_reg + CNT_W'(1);
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b00000, len_reg, first_reg,
                                     TOTAL_W'(used_reg), status_reg};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

endmodule
